>>> hw/rtl/mlpq_pkg.sv
`default_nettype none

package mlpq_pkg;

    // request codes
    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_REMOVE = 1'b1;

    // result status codes
    typedef enum logic [1:0] {
        ST_DONE      = 2'd0,
        ST_OVERFLOW  = 2'd1,
        ST_UNDERFLOW = 2'd2
    } t_status;

    // entry store access strobes
    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } t_mem_ctl;

    // outcome of one request, carried to the result stage
    typedef struct packed {
        t_status status;
        logic    took;
    } t_resp;

endpackage

`default_nettype wire

>>> hw/rtl/mlpq_store.sv
`default_nettype none

module mlpq_store #(
    parameter int DEPTH  = 24,
    parameter int ADDR_W = 5,
    parameter int DATA_W = 32
) (
    input  wire                 i_clk,
    input  mlpq_pkg::t_mem_ctl  i_ctl,
    input  wire  [ADDR_W-1:0]   i_addr,
    input  wire  [DATA_W-1:0]   i_wr_data,
    output logic [DATA_W-1:0]   o_rd_data
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rd_data;

    // single port slot memory, registered read
    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_mem[i_addr] <= i_wr_data;
        end
        if (i_ctl.rd_en) begin
            r_rd_data <= r_mem[i_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

>>> hw/rtl/mlpq_ctrl.sv
`default_nettype none

module mlpq_ctrl #(
    parameter int LEVELS      = 3,
    parameter int LEVEL_DEPTH = 8,
    parameter int LVL_W       = 2,
    parameter int PTR_W       = 4,
    parameter int ADDR_W      = 5
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_fire,
    input  wire                 i_opcode,
    input  wire  [1:0]          i_priority_req,
    output mlpq_pkg::t_mem_ctl  o_mem_ctl,
    output logic [ADDR_W-1:0]   o_mem_addr,
    output mlpq_pkg::t_resp     o_resp,
    output logic [LVL_W-1:0]    o_level
);

    logic [PTR_W-1:0] r_head [LEVELS];
    logic [PTR_W-1:0] r_tail [LEVELS];
    logic [PTR_W-1:0] n_head [LEVELS];
    logic [PTR_W-1:0] n_tail [LEVELS];

    logic [LVL_W-1:0] prio_idx;
    logic             prio_ok;
    logic             lvl_full;
    logic             found;
    logic [LVL_W-1:0] pick;

    // insert target level and its fill check
    always_comb begin
        prio_idx = LVL_W'(i_priority_req);
        prio_ok  = (32'(i_priority_req) < LEVELS);
        lvl_full = prio_ok ? (r_tail[prio_idx] == PTR_W'(LEVEL_DEPTH)) : 1'b1;
    end

    // lowest numbered non-empty level
    always_comb begin
        found = 1'b0;
        pick  = '0;
        for (int l = LEVELS - 1; l >= 0; l--) begin
            if (r_head[l] != r_tail[l]) begin
                found = 1'b1;
                pick  = LVL_W'(l);
            end
        end
    end

    // decision, memory access and pointer updates
    always_comb begin
        o_mem_ctl   = '0;
        o_mem_addr  = '0;
        o_resp      = '{status: mlpq_pkg::ST_DONE, took: 1'b0};
        o_level     = '0;
        n_head      = r_head;
        n_tail      = r_tail;
        if (i_opcode == mlpq_pkg::OP_INSERT) begin
            if (lvl_full) begin
                o_resp.status = mlpq_pkg::ST_OVERFLOW;
            end else begin
                o_mem_ctl.wr_en = i_fire;
                o_mem_addr = ADDR_W'(prio_idx) * ADDR_W'(LEVEL_DEPTH)
                           + ADDR_W'(r_tail[prio_idx]);
                if (i_fire) begin
                    n_tail[prio_idx] = r_tail[prio_idx] + PTR_W'(1);
                end
            end
        end else begin
            if (!found) begin
                o_resp.status = mlpq_pkg::ST_UNDERFLOW;
            end else begin
                o_mem_ctl.rd_en = i_fire;
                o_mem_addr = ADDR_W'(pick) * ADDR_W'(LEVEL_DEPTH)
                           + ADDR_W'(r_head[pick]);
                o_resp.took = 1'b1;
                o_level     = pick;
                if (i_fire) begin
                    n_head[pick] = r_head[pick] + PTR_W'(1);
                end
            end
        end
    end

    // head and tail pointers, cleared at reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int l = 0; l < LEVELS; l++) begin
                r_head[l] <= '0;
                r_tail[l] <= '0;
            end
        end else begin
            r_head <= n_head;
            r_tail <= n_tail;
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/multi_level_priority_queue.sv
`default_nettype none

// Multi-level priority queue: LEVELS linear FIFOs, level 0 served first.
// Request channel: drive i_opcode, i_priority_req and i_data_value with start
// high; the request is taken at a rising edge where start is high and busy is
// low. An insert appends i_data_value to its level or reports overflow once
// that level has taken LEVEL_DEPTH entries (slots are never reused) or when
// the level does not exist. A remove takes the head of the lowest non-empty
// level, or reports underflow. Result channel: o_done is high for exactly one
// cycle, the cycle after the request edge, with o_status, o_removed_value and
// o_served_level valid. One request can be taken every cycle: the slot memory
// is accessed at the request edge and its registered read data forms the
// result. The receiver cannot stall; results must be taken when o_done is
// high. busy is high during reset and low after; reset empties every level and
// drops any pending result. The slot memory itself is not cleared.
module multi_level_priority_queue #(
    parameter int LEVELS      = 3,
    parameter int LEVEL_DEPTH = 8
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         start,
    output logic        busy,
    input  wire         i_opcode,
    input  wire  [1:0]  i_priority_req,
    input  wire  [31:0] i_data_value,
    output logic        o_done,
    output logic [1:0]  o_status,
    output logic [31:0] o_removed_value,
    output logic [1:0]  o_served_level
);

    localparam int LVL_W  = $clog2(LEVELS);
    localparam int PTR_W  = $clog2(LEVEL_DEPTH + 1);
    localparam int DEPTH  = LEVELS * LEVEL_DEPTH;
    localparam int ADDR_W = $clog2(DEPTH);

    logic               r_ready;
    logic               r_done;
    mlpq_pkg::t_resp    r_resp;
    logic [LVL_W-1:0]   r_level;

    logic               fire;
    mlpq_pkg::t_mem_ctl mem_ctl;
    logic [ADDR_W-1:0]  mem_addr;
    logic [31:0]        rd_data;
    mlpq_pkg::t_resp    resp;
    logic [LVL_W-1:0]   level;

    assign busy = !r_ready;
    assign fire = start && r_ready;

    mlpq_ctrl #(
        .LEVELS      (LEVELS),
        .LEVEL_DEPTH (LEVEL_DEPTH),
        .LVL_W       (LVL_W),
        .PTR_W       (PTR_W),
        .ADDR_W      (ADDR_W)
    ) u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_fire         (fire),
        .i_opcode       (i_opcode),
        .i_priority_req (i_priority_req),
        .o_mem_ctl      (mem_ctl),
        .o_mem_addr     (mem_addr),
        .o_resp         (resp),
        .o_level        (level)
    );

    mlpq_store #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W),
        .DATA_W (32)
    ) u_store (
        .i_clk     (i_clk),
        .i_ctl     (mem_ctl),
        .i_addr    (mem_addr),
        .i_wr_data (i_data_value),
        .o_rd_data (rd_data)
    );

    // ready after reset, result strobe in the cycle after each request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ready <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            r_ready <= 1'b1;
            r_done  <= fire;
        end
    end

    // result info held beside the memory read
    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_resp  <= resp;
            r_level <= level;
        end
    end

    // result ports, zero value and level unless a remove succeeded
    assign o_done          = r_done;
    assign o_status        = r_resp.status;
    assign o_removed_value = r_resp.took ? rd_data : 32'd0;
    assign o_served_level  = r_resp.took ? 2'(r_level) : 2'd0;

endmodule

`default_nettype wire

>>> bench/tb_multi_level_priority_queue.sv
`timescale 1ns / 1ps

module tb_multi_level_priority_queue;

    localparam int LEVELS       = 3;
    localparam int LEVEL_DEPTH  = 8;
    localparam int RANDOM_COUNT = 1030;
    localparam int SETTLE       = 4;
    localparam int DRAIN_LIMIT  = 1000;

    // one expected result
    typedef struct {
        mlpq_pkg::t_status status;
        logic [31:0]       value;
        logic [1:0]        level;
    } t_outcome;

    // tracks the level fifos and the results each request should produce
    class queue_tracker;
        logic [31:0] slots [LEVELS][LEVEL_DEPTH];
        int unsigned head_ptr [LEVELS];
        int unsigned tail_ptr [LEVELS];
        t_outcome    pending_results [$];
        int          errors;
        int          requests;
        int          stored;
        int          served;
        int          overflows;
        int          underflows;

        function void note_request(logic op, logic [1:0] prio, logic [31:0] val);
            t_outcome res;
            bit       found;
            res.status = mlpq_pkg::ST_DONE;
            res.value  = '0;
            res.level  = '0;
            found      = 1'b0;
            requests++;
            if (op == mlpq_pkg::OP_INSERT) begin
                // out-of-range level is refused like a full one
                if (prio >= LEVELS) begin
                    res.status = mlpq_pkg::ST_OVERFLOW;
                end else if (tail_ptr[prio] >= LEVEL_DEPTH) begin
                    res.status = mlpq_pkg::ST_OVERFLOW;
                end else begin
                    slots[prio][tail_ptr[prio]] = val;
                    tail_ptr[prio]++;
                end
            end else begin
                // lowest-numbered non-empty level wins
                for (int lv = 0; lv < LEVELS; lv++) begin
                    if (!found && head_ptr[lv] < tail_ptr[lv]) begin
                        res.value  = slots[lv][head_ptr[lv]];
                        res.level  = 2'(lv);
                        head_ptr[lv]++;
                        found = 1'b1;
                    end
                end
                if (!found)
                    res.status = mlpq_pkg::ST_UNDERFLOW;
            end
            case (res.status)
                mlpq_pkg::ST_OVERFLOW:  overflows++;
                mlpq_pkg::ST_UNDERFLOW: underflows++;
                default: begin
                    if (op == mlpq_pkg::OP_INSERT)
                        stored++;
                    else
                        served++;
                end
            endcase
            pending_results.push_back(res);
        endfunction

        function void check_result(logic [1:0] st, logic [31:0] val, logic [1:0] lvl);
            t_outcome want;
            if (pending_results.size() == 0) begin
                $error("result with no request outstanding: status %0d", st);
                errors++;
                return;
            end
            want = pending_results.pop_front();
            if (st !== want.status) begin
                $error("status: expected %0d, got %0d", want.status, st);
                errors++;
            end
            if (val !== want.value) begin
                $error("removed_value: expected %h, got %h", want.value, val);
                errors++;
            end
            if (lvl !== want.level) begin
                $error("served_level: expected %0d, got %0d", want.level, lvl);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic        i_opcode;
    logic [1:0]  i_priority_req;
    logic [31:0] i_data_value;
    logic        o_done;
    logic [1:0]  o_status;
    logic [31:0] o_removed_value;
    logic [1:0]  o_served_level;

    queue_tracker tracker = new;

    multi_level_priority_queue #(
        .LEVELS      (LEVELS),
        .LEVEL_DEPTH (LEVEL_DEPTH)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_opcode        (i_opcode),
        .i_priority_req  (i_priority_req),
        .i_data_value    (i_data_value),
        .o_done          (o_done),
        .o_status        (o_status),
        .o_removed_value (o_removed_value),
        .o_served_level  (o_served_level)
    );

    always #1 i_clk = ~i_clk;

    // check results and record accepted requests at each rising edge
    always @(posedge i_clk) begin
        if (o_done === 1'b1)
            tracker.check_result(o_status, o_removed_value, o_served_level);
        if (i_rst_n && start && !busy)
            tracker.note_request(i_opcode, i_priority_req, i_data_value);
    end

    // present one request and hold it until taken
    task automatic issue(input logic op, input logic [1:0] prio, input logic [31:0] val);
        @(negedge i_clk);
        start          <= 1'b1;
        i_opcode       <= op;
        i_priority_req <= prio;
        i_data_value   <= val;
        @(posedge i_clk);
        while (busy !== 1'b0)
            @(posedge i_clk);
    endtask

    // idle the request side for some cycles
    task automatic pause(input int cycles);
        if (cycles > 0) begin
            @(negedge i_clk);
            start <= 1'b0;
            repeat (cycles - 1) @(negedge i_clk);
        end
    endtask

    // stop sending until every outstanding result has been checked
    task automatic wait_idle();
        @(negedge i_clk);
        start <= 1'b0;
        while (tracker.pending_results.size() != 0)
            @(negedge i_clk);
    endtask

    // data with frequent extremes
    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 7))
            0:       return 32'h8000_0000;
            1:       return 32'h7fff_ffff;
            2:       return 32'h0000_0000;
            3:       return 32'hffff_ffff;
            default: return $urandom;
        endcase
    endfunction

    initial begin
        int sent;
        int burst;
        int waited;
        logic op;

        start          <= 1'b0;
        i_opcode       <= mlpq_pkg::OP_INSERT;
        i_priority_req <= '0;
        i_data_value   <= '0;
        i_rst_n        <= 1'b0;
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // remove with every level empty, insert at a level that does not exist
        issue(mlpq_pkg::OP_REMOVE, 2'd0, 32'h1234_5678);
        issue(mlpq_pkg::OP_INSERT, 2'd3, 32'hdead_beef);

        // extreme values at every level, two at level 0, drained in priority order
        issue(mlpq_pkg::OP_INSERT, 2'd2, 32'h8000_0000);
        issue(mlpq_pkg::OP_INSERT, 2'd1, 32'h7fff_ffff);
        issue(mlpq_pkg::OP_INSERT, 2'd0, 32'h0000_0000);
        issue(mlpq_pkg::OP_INSERT, 2'd0, 32'hffff_ffff);
        repeat (5) issue(mlpq_pkg::OP_REMOVE, 2'd3, 32'hffff_ffff);

        // fill level two to the top; its first slot was used above, so the last of these inserts overflows
        for (int k = 0; k < LEVEL_DEPTH; k++)
            issue(mlpq_pkg::OP_INSERT, 2'd2, pick_value());

        // let everything drain before the random part
        wait_idle();

        // random requests in bursts, some back to back, some with gaps
        sent = 0;
        while (sent < RANDOM_COUNT) begin
            burst = $urandom_range(1, 16);
            for (int k = 0; k < burst && sent < RANDOM_COUNT; k++) begin
                op = ($urandom_range(0, 99) < 55) ? mlpq_pkg::OP_INSERT
                                                  : mlpq_pkg::OP_REMOVE;
                issue(op, 2'($urandom_range(0, 3)), pick_value());
                sent++;
                if (sent == RANDOM_COUNT / 2)
                    wait_idle();
            end
            if ($urandom_range(0, 2) == 0)
                pause($urandom_range(1, 7));
        end

        // wait for the tail of the results, bounded
        @(negedge i_clk);
        start  <= 1'b0;
        waited = 0;
        while (tracker.pending_results.size() != 0 && waited < DRAIN_LIMIT) begin
            @(negedge i_clk);
            waited++;
        end
        repeat (SETTLE) @(negedge i_clk);
        if (tracker.pending_results.size() != 0) begin
            $error("%0d results never arrived", tracker.pending_results.size());
            tracker.errors += tracker.pending_results.size();
        end

        $display("covered %0d requests: %0d stored, %0d served", tracker.requests,
                 tracker.stored, tracker.served);
        $display("refused inserts %0d, removes on empty queue %0d", tracker.overflows,
                 tracker.underflows);
        if (tracker.errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    // watchdog
    initial begin
        #400000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule

>>> files.f
hw/rtl/mlpq_pkg.sv
hw/rtl/mlpq_store.sv
hw/rtl/mlpq_ctrl.sv
hw/rtl/multi_level_priority_queue.sv
bench/tb_multi_level_priority_queue.sv
